@@ hdl/hqpt_pkg.sv @@
// ----------------------------------------------------------------------------
// hqpt_pkg
// Shared types, register indexes and reset values of the hall position tracker.
// ----------------------------------------------------------------------------
package hqpt_pkg;

	localparam int POSITION_BITS_DEF = 32;

	localparam int CFG_INDEX_BITS = 3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HALL_MODE        = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT_DIRECTION = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_LIMIT   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD_LIMIT     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STALL_SPEED      = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOST_THRESHOLD   = 3'd5;

	// Reset values
	localparam logic [1:0]  RST_HALL_MODE        = 2'd3;
	localparam logic        RST_INVERT_DIRECTION = 1'b0;
	localparam logic [7:0]  RST_DEBOUNCE_LIMIT   = 8'd6;
	localparam logic [15:0] RST_PERIOD_LIMIT     = 16'd6553;
	localparam logic [15:0] RST_STALL_SPEED      = 16'd65535;
	localparam logic [15:0] RST_LOST_THRESHOLD   = 16'd64;

	// Hall mode codes
	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_QUAD = 2'd3;

	// Quadrature step codes after bit swap and xor
	localparam logic [1:0] QUAD_FWD = 2'b01;
	localparam logic [1:0] QUAD_REV = 2'b10;

	typedef struct packed {
		logic [1:0]  hall_mode;
		logic        invert_direction;
		logic [7:0]  debounce_limit;
		logic [15:0] period_limit;
		logic [15:0] stall_speed;
		logic [15:0] lost_threshold;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  debounce;
		logic [15:0] speed;
		logic        enc;
		logic        edge_hit;
		logic [31:0] edges;
	} hall_out_t;

endpackage

@@ hdl/hall_quadrature_position_tracker.sv @@
// ----------------------------------------------------------------------------
// hall_quadrature_position_tracker
// Debounced two-hall position and speed tracker for one motor.
// ----------------------------------------------------------------------------
// One sample tick per transfer on the input channel, one result per tick.
// A tick is captured in an input register, then processed by a single pass
// of debounce, period, decode and compare logic that writes the result
// register, so a new tick is taken every clock unless the input stalls. A
// tick's result is presented on the output from the result register. The
// result register lets the input keep flowing while a finished result waits;
// the input stalls only when both the input register and the result register
// are full and the result is not taken. Configuration writes must be made
// while no tick is in flight.
module hall_quadrature_position_tracker
	import hqpt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      hall_one,
	input  logic                      hall_two,
	input  logic                      moving_out,
	input  logic                      moving_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        position,
	output logic [15:0]               speed_period,
	output logic                      edge_seen,
	output logic                      lost_pulses
);

	cfg_t cfg;

	logic valid_s1;
	logic hall_one_s1;
	logic hall_two_s1;
	logic moving_out_s1;
	logic moving_in_s1;

	logic [7:0]               deb_q;
	logic [15:0]              speed_q;
	logic [1:0]               enc_cur_q;
	logic [1:0]               enc_prev_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     lost_q;

	logic advance;
	logic step;

	hall_out_t h1;
	hall_out_t h2;

	logic [1:0]               enc_nx;
	logic [1:0]               code;
	logic [1:0]               enc_prev_nx;
	logic [POSITION_BITS-1:0] pos_nx;
	logic [31:0]              edge_diff;
	logic                     lost_nx;

	hqpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = !out_valid || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hall_one_s1   <= hall_one;
			hall_two_s1   <= hall_two;
			moving_out_s1 <= moving_out;
			moving_in_s1  <= moving_in;
		end
	end

	// hall one acts first on the shared debounce count and the speed latch
	hqpt_hall u_hall_one (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (cfg.hall_mode[0]),
		.step     (step),
		.level    (hall_one_s1),
		.cfg      (cfg),
		.deb_in   (deb_q),
		.speed_in (speed_q),
		.enc_in   (enc_cur_q[0]),
		.result   (h1)
	);

	hqpt_hall u_hall_two (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (cfg.hall_mode[1]),
		.step     (step),
		.level    (hall_two_s1),
		.cfg      (cfg),
		.deb_in   (h1.debounce),
		.speed_in (h1.speed),
		.enc_in   (enc_cur_q[1]),
		.result   (h2)
	);

	assign enc_nx = {h2.enc, h1.enc};
	assign code   = {enc_prev_q[0], enc_prev_q[1]} ^ enc_nx;

	always_comb begin
		edge_diff   = (h1.edges >= h2.edges) ? (h1.edges - h2.edges) : (h2.edges - h1.edges);
		pos_nx      = pos_q;
		enc_prev_nx = enc_prev_q;
		lost_nx     = lost_q;
		if (cfg.hall_mode == MODE_QUAD) begin
			enc_prev_nx = enc_nx;
			case (code)
				QUAD_FWD: pos_nx = cfg.invert_direction ? pos_q - POSITION_BITS'(1)
				                                        : pos_q + POSITION_BITS'(1);
				QUAD_REV: pos_nx = cfg.invert_direction ? pos_q + POSITION_BITS'(1)
				                                        : pos_q - POSITION_BITS'(1);
				default: ;
			endcase
			if (edge_diff >= {16'd0, cfg.lost_threshold}) begin
				lost_nx = 1'b1;
			end
		end else if (cfg.hall_mode != MODE_OFF) begin
			enc_prev_nx = enc_nx;
			// single hall: step by two in the hinted direction, outward wins
			if (enc_nx != enc_prev_q) begin
				if (moving_out_s1) begin
					pos_nx = pos_q + POSITION_BITS'(2);
				end else if (moving_in_s1) begin
					pos_nx = pos_q - POSITION_BITS'(2);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q      <= '0;
			speed_q    <= '0;
			enc_cur_q  <= '0;
			enc_prev_q <= '0;
			pos_q      <= '0;
			lost_q     <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (step) begin
				deb_q      <= h2.debounce;
				speed_q    <= h2.speed;
				enc_cur_q  <= enc_nx;
				enc_prev_q <= enc_prev_nx;
				pos_q      <= pos_nx;
				lost_q     <= lost_nx;
			end
			if (advance) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			position     <= 32'(signed'(pos_nx));
			speed_period <= h2.speed;
			edge_seen    <= h1.edge_hit | h2.edge_hit;
			lost_pulses  <= lost_nx;
		end
	end

	a_lost_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lost_q |=> lost_q)
		else $error("lost pulse flag cleared without reset");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pos_q) && $stable(enc_prev_q))
		else $error("position moved without a tick");

	a_speed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(speed_q) && $stable(deb_q))
		else $error("speed or debounce changed without a tick");

endmodule

@@ hdl/hqpt_cfg.sv @@
// ----------------------------------------------------------------------------
// hqpt_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module hqpt_cfg
	import hqpt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [15:0]               cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hall_mode        <= RST_HALL_MODE;
			cfg_q.invert_direction <= RST_INVERT_DIRECTION;
			cfg_q.debounce_limit   <= RST_DEBOUNCE_LIMIT;
			cfg_q.period_limit     <= RST_PERIOD_LIMIT;
			cfg_q.stall_speed      <= RST_STALL_SPEED;
			cfg_q.lost_threshold   <= RST_LOST_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HALL_MODE:        cfg_q.hall_mode        <= cfg_data[1:0];
				CFG_INVERT_DIRECTION: cfg_q.invert_direction <= cfg_data[0];
				CFG_DEBOUNCE_LIMIT:   cfg_q.debounce_limit   <= cfg_data[7:0];
				CFG_PERIOD_LIMIT:     cfg_q.period_limit     <= cfg_data;
				CFG_STALL_SPEED:      cfg_q.stall_speed      <= cfg_data;
				CFG_LOST_THRESHOLD:   cfg_q.lost_threshold   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/hqpt_hall.sv @@
// ----------------------------------------------------------------------------
// hqpt_hall
// One hall channel: debounce step on the shared counter, half-period counters,
// speed latch and rising-edge count.
// ----------------------------------------------------------------------------
module hqpt_hall
	import hqpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        enable,
	input  logic        step,
	input  logic        level,
	input  cfg_t        cfg,
	input  logic [7:0]  deb_in,
	input  logic [15:0] speed_in,
	input  logic        enc_in,
	output hall_out_t   result
);

	logic        last_q;
	logic [15:0] per_high_q;
	logic [15:0] per_low_q;
	logic [31:0] edges_q;

	logic        last_nx;
	logic [15:0] high_nx;
	logic [15:0] low_nx;
	logic [31:0] edges_nx;
	logic [7:0]  deb_up;
	logic [7:0]  deb_nx;
	logic [15:0] speed_nx;
	logic        enc_nx;
	logic        take;

	always_comb begin
		deb_up   = deb_in + 8'd1;
		take     = 1'b0;
		deb_nx   = deb_in;
		speed_nx = speed_in;
		enc_nx   = enc_in;
		last_nx  = last_q;
		high_nx  = per_high_q;
		low_nx   = per_low_q;
		edges_nx = edges_q;
		if (enable) begin
			if (level != last_q) begin
				deb_nx = deb_up;
				if (deb_up > cfg.debounce_limit) begin
					take    = 1'b1;
					deb_nx  = '0;
					last_nx = level;
					enc_nx  = level;
					if (level) begin
						speed_nx = per_high_q;
						high_nx  = '0;
						edges_nx = edges_q + 32'd1;
					end else begin
						speed_nx = per_low_q;
						low_nx   = '0;
					end
				end
			end else if (deb_in != '0) begin
				deb_nx = deb_in - 8'd1;
			end
			// stall overrides any latch made this tick
			if (high_nx < cfg.period_limit) begin
				high_nx = high_nx + 16'd1;
			end else begin
				speed_nx = cfg.stall_speed;
			end
			if (low_nx < cfg.period_limit) begin
				low_nx = low_nx + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= 1'b0;
			per_high_q <= '0;
			per_low_q  <= '0;
			edges_q    <= '0;
		end else if (step && enable) begin
			last_q     <= last_nx;
			per_high_q <= high_nx;
			per_low_q  <= low_nx;
			edges_q    <= edges_nx;
		end
	end

	assign result.debounce = deb_nx;
	assign result.speed    = speed_nx;
	assign result.enc      = enc_nx;
	assign result.edge_hit = take;
	assign result.edges    = edges_nx;

endmodule

@@ dv/hqpt_position_checker.sv @@
// ----------------------------------------------------------------------------
// hqpt_position_checker
// Watches the tick and result channels of the hall position tracker, tracks
// its own copy of the register and counter state, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module hqpt_position_checker
	import hqpt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      hall_one,
	input  logic                      hall_two,
	input  logic                      moving_out,
	input  logic                      moving_in,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic signed [31:0]        position,
	input  logic [15:0]               speed_period,
	input  logic                      edge_seen,
	input  logic                      lost_pulses,
	output int unsigned               fail_count,
	output int unsigned               results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] position;
		logic [15:0]        speed;
		logic               edge_hit;
		logic               lost;
	} tick_result_t;

	tick_result_t due_results[$];

	// register copy
	logic [1:0]  mode_r;
	logic        inv_r;
	logic [7:0]  deb_lim;
	logic [15:0] per_lim;
	logic [15:0] stall_val;
	logic [15:0] lost_thr;

	// tracker state, index 0 is hall one, index 1 is hall two
	logic [1:0]         last_level;
	logic [7:0]         bounce;
	logic [15:0]        per_hi [2];
	logic [15:0]        per_lo [2];
	logic [31:0]        rises [2];
	logic [1:0]         enc_now;
	logic [1:0]         enc_prev;
	logic signed [31:0] pos_count;
	logic [15:0]        speed;
	logic               lost;

	task automatic clear_tracker();
		mode_r     = RST_HALL_MODE;
		inv_r      = RST_INVERT_DIRECTION;
		deb_lim    = RST_DEBOUNCE_LIMIT;
		per_lim    = RST_PERIOD_LIMIT;
		stall_val  = RST_STALL_SPEED;
		lost_thr   = RST_LOST_THRESHOLD;
		last_level = '0;
		bounce     = '0;
		for (int h = 0; h < 2; h++) begin
			per_hi[h] = '0;
			per_lo[h] = '0;
			rises[h]  = '0;
		end
		enc_now   = '0;
		enc_prev  = '0;
		pos_count = '0;
		speed     = '0;
		lost      = 1'b0;
	endtask

	task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
		case (idx)
			CFG_HALL_MODE: begin
				mode_r = data[1:0];
			end
			CFG_INVERT_DIRECTION: begin
				inv_r = data[0];
			end
			CFG_DEBOUNCE_LIMIT: begin
				deb_lim = data[7:0];
			end
			CFG_PERIOD_LIMIT: begin
				per_lim = data;
			end
			CFG_STALL_SPEED: begin
				stall_val = data;
			end
			CFG_LOST_THRESHOLD: begin
				lost_thr = data;
			end
			default: begin
			end
		endcase
	endtask

	// One hall through the shared debounce counter and its period counters.
	function automatic logic track_hall(input int unsigned h, input logic level);
		logic hit;
		hit = 1'b0;
		if (level != last_level[h]) begin
			bounce = bounce + 8'd1;
			if (bounce > deb_lim) begin
				if (level) begin
					speed = per_hi[h];
					per_hi[h] = '0;
					rises[h] = rises[h] + 32'd1;
				end else begin
					speed = per_lo[h];
					per_lo[h] = '0;
				end
				enc_now[h] = level;
				bounce = '0;
				last_level[h] = level;
				hit = 1'b1;
			end
		end else if (bounce != 8'd0) begin
			bounce = bounce - 8'd1;
		end
		// stall overrides any latch made this tick
		if (per_hi[h] < per_lim)
			per_hi[h] = per_hi[h] + 16'd1;
		else
			speed = stall_val;
		if (per_lo[h] < per_lim)
			per_lo[h] = per_lo[h] + 16'd1;
		return hit;
	endfunction

	function automatic tick_result_t advance_tracker(input logic h1, input logic h2,
		input logic mv_out, input logic mv_in);
		tick_result_t r;
		logic         hit;
		logic [1:0]   code;
		logic [31:0]  gap;
		hit = 1'b0;
		if (mode_r[0])
			hit = track_hall(0, h1) | hit;
		if (mode_r[1])
			hit = track_hall(1, h2) | hit;
		if (mode_r == MODE_QUAD) begin
			code = {enc_prev[0], enc_prev[1]} ^ enc_now;
			enc_prev = enc_now;
			if (code == QUAD_FWD)
				pos_count = inv_r ? pos_count - 32'sd1 : pos_count + 32'sd1;
			else if (code == QUAD_REV)
				pos_count = inv_r ? pos_count + 32'sd1 : pos_count - 32'sd1;
			gap = (rises[0] >= rises[1]) ? rises[0] - rises[1] : rises[1] - rises[0];
			if (gap >= {16'd0, lost_thr})
				lost = 1'b1;
		end else if (mode_r != MODE_OFF) begin
			if (enc_now != enc_prev) begin
				if (mv_out)
					pos_count = pos_count + 32'sd2;
				else if (mv_in)
					pos_count = pos_count - 32'sd2;
			end
			enc_prev = enc_now;
		end
		r.position = pos_count;
		r.speed    = speed;
		r.edge_hit = hit;
		r.lost     = lost;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		logic         bad;
		if (!arst_n) begin
			clear_tracker();
			due_results.delete();
			fail_count  = 0;
			results_due = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				due_results.push_back(advance_tracker(hall_one, hall_two, moving_out, moving_in));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing expected, position %0d speed %0d",
						$time, position, speed_period);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					bad  = 1'b0;
					if (position !== want.position) begin
						$display("%0t: position expected %0d got %0d", $time, want.position,
							position);
						bad = 1'b1;
					end
					if (speed_period !== want.speed) begin
						$display("%0t: speed_period expected %0d got %0d", $time, want.speed,
							speed_period);
						bad = 1'b1;
					end
					if (edge_seen !== want.edge_hit) begin
						$display("%0t: edge_seen expected %0b got %0b", $time, want.edge_hit,
							edge_seen);
						bad = 1'b1;
					end
					if (lost_pulses !== want.lost) begin
						$display("%0t: lost_pulses expected %0b got %0b", $time, want.lost,
							lost_pulses);
						bad = 1'b1;
					end
					if (bad)
						fail_count++;
				end
			end
			results_due = due_results.size();
		end
	end

endmodule

@@ dv/hall_quadrature_position_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// hall_quadrature_position_tracker_tb
// Drives hall sample ticks and register writes into the position tracker
// across a series of register settings, with random idling on both channels
// and one long output back-pressure stretch. Checking is done by the checker.
// ----------------------------------------------------------------------------
module hall_quadrature_position_tracker_tb;
	import hqpt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int BACKLOG_TICKS = 200;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [15:0]               cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      hall_one;
	logic                      hall_two;
	logic                      moving_out;
	logic                      moving_in;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [31:0]        position;
	logic [15:0]               speed_period;
	logic                      edge_seen;
	logic                      lost_pulses;

	int unsigned fail_count;
	int unsigned results_due;
	int unsigned cycle_count;

	bit   steady;
	bit   backlog_req;
	bit   backlog_done;
	int   backlog_left;
	logic [7:0] deb_now;
	logic cur_one;
	logic cur_two;

	hall_quadrature_position_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.hall_one     (hall_one),
		.hall_two     (hall_two),
		.moving_out   (moving_out),
		.moving_in    (moving_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.speed_period (speed_period),
		.edge_seen    (edge_seen),
		.lost_pulses  (lost_pulses)
	);

	hqpt_position_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.hall_one     (hall_one),
		.hall_two     (hall_two),
		.moving_out   (moving_out),
		.moving_in    (moving_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.speed_period (speed_period),
		.edge_seen    (edge_seen),
		.lost_pulses  (lost_pulses),
		.fail_count   (fail_count),
		.results_due  (results_due)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off when asked for.
	always @(negedge clk) begin
		if (backlog_req && !backlog_done) begin
			backlog_left = BACKLOG_TICKS;
			backlog_done = 1'b1;
		end
		if (backlog_left != 0) begin
			backlog_left--;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 30);
		end
	end

	// Entered and left at a falling edge.
	task automatic send_tick(input logic h1, input logic h2, input logic mv_out,
		input logic mv_in);
		while (!steady && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		hall_one   <= h1;
		hall_two   <= h2;
		moving_out <= mv_out;
		moving_in  <= mv_in;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Drain all ticks in flight, then rewrite every register. Unused upper
	// data bits are filled at random.
	task automatic set_config(input logic [1:0] mode, input logic inv, input logic [7:0] deb,
		input logic [15:0] per, input logic [15:0] stall, input logic [15:0] thr);
		logic [15:0] pad;
		in_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		pad = 16'($urandom);
		write_register(CFG_HALL_MODE, {pad[15:2], mode});
		pad = 16'($urandom);
		write_register(CFG_INVERT_DIRECTION, {pad[15:1], inv});
		pad = 16'($urandom);
		write_register(CFG_DEBOUNCE_LIMIT, {pad[15:8], deb});
		write_register(CFG_PERIOD_LIMIT, per);
		write_register(CFG_STALL_SPEED, stall);
		write_register(CFG_LOST_THRESHOLD, thr);
		deb_now = deb;
	endtask

	// Mostly clean quadrature steps held past the debounce limit, with short
	// glitches, occasional double-hall jumps and bursts of noise.
	task automatic drive_pattern(input int count, input int noise_pct, input int jump_pct);
		int sent;
		int hold;
		int burst;
		bit fwd;
		sent = 0;
		fwd  = 1'b1;
		while (sent < count) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				burst = int'($urandom_range(1, 6));
				repeat (burst) begin
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					sent++;
				end
			end else begin
				if ($urandom_range(0, 99) < 20)
					fwd = !fwd;
				if ($urandom_range(0, 99) < jump_pct) begin
					cur_one = !cur_one;
					cur_two = !cur_two;
				end else if ((cur_one == cur_two) == fwd) begin
					cur_one = !cur_one;
				end else begin
					cur_two = !cur_two;
				end
				hold = int'(deb_now) + 1 + int'($urandom_range(0, 6));
				repeat (hold) begin
					if ($urandom_range(0, 99) < 5)
						send_tick(!cur_one, cur_two, 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
					else
						send_tick(cur_one, cur_two, 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_HALL_MODE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		hall_one     = 1'b0;
		hall_two     = 1'b0;
		moving_out   = 1'b0;
		moving_in    = 1'b0;
		out_ready    = 1'b0;
		steady       = 1'b0;
		backlog_req  = 1'b0;
		backlog_done = 1'b0;
		backlog_left = 0;
		cycle_count  = 0;
		deb_now      = RST_DEBOUNCE_LIMIT;
		cur_one      = 1'b0;
		cur_two      = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Quadrature with instant edges and a zero period limit: always stalled,
		// forward and reverse steps, double changes and a hold.
		set_config(MODE_QUAD, 1'b0, 8'd0, 16'd0, 16'hA5A5, 16'hFFFF);
		send_tick(1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b0, 1'b1, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0, 1'b0);
		cur_one = 1'b1;
		cur_two = 1'b1;

		// Hall one alone: every hint combination, including none.
		set_config(2'd1, 1'b0, 8'd0, 16'd3, 16'h5A5A, 16'hFFFF);
		send_tick(1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0, 1'b1);

		// Hall two alone.
		set_config(2'd2, 1'b1, 8'd0, 16'd3, 16'h5A5A, 16'hFFFF);
		send_tick(1'b0, 1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1, 1'b1);

		// Both halls off: state frozen.
		set_config(MODE_OFF, 1'b0, 8'd0, 16'd3, 16'h5A5A, 16'hFFFF);
		send_tick(1'b0, 1'b0, 1'b1, 1'b0);
		send_tick(1'b1, 1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1, 1'b1);
		cur_one = 1'b0;
		cur_two = 1'b1;

		// Random phases
		set_config(MODE_QUAD, 1'b0, 8'd0, RST_PERIOD_LIMIT, RST_STALL_SPEED, 16'hFFFF);
		steady = 1'b1;
		drive_pattern(300, 10, 5);
		steady = 1'b0;
		drive_pattern(100, 25, 10);

		set_config(MODE_QUAD, 1'b1, 8'd0, 16'd40, 16'($urandom), 16'hFFFF);
		backlog_req = 1'b1;
		drive_pattern(300, 25, 10);

		set_config(2'd1, 1'b0, 8'd3, 16'd255, 16'($urandom), 16'hFFFF);
		drive_pattern(300, 20, 5);

		// Limit at its top: the debounce count wraps before it can pass it.
		set_config(2'd2, 1'b0, 8'd255, 16'hFFFF, 16'($urandom), 16'hFFFF);
		drive_pattern(100, 100, 0);

		set_config(2'd2, 1'b1, 8'd1, 16'd100, 16'($urandom), 16'hFFFF);
		drive_pattern(250, 20, 5);

		// Shared counter only passes the limit with both halls changing together.
		set_config(MODE_QUAD, 1'b0, RST_DEBOUNCE_LIMIT, RST_PERIOD_LIMIT, RST_STALL_SPEED,
			RST_LOST_THRESHOLD);
		drive_pattern(200, 25, 50);

		set_config(MODE_QUAD, 1'b0, 8'd0, 16'd500, 16'($urandom),
			16'($urandom_range(1, 40)));
		drive_pattern(250, 25, 10);

		// Zero threshold flags at once.
		set_config(MODE_QUAD, 1'b1, 8'd0, 16'd20, 16'($urandom), 16'd0);
		drive_pattern(200, 30, 10);

		in_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
